>>> hdl/bftr_pkg.sv
// bftr_pkg: shared types and constants for the bitmap font text renderer
// used by bftr_glyph_rom, bftr_seq and bitmap_font_text_renderer_core
package bftr_pkg;

	localparam int unsigned GLYPH_SIZE  = 8;
	localparam int unsigned GLYPH_COUNT = 36;
	localparam int unsigned GLYPH_W     = $clog2(GLYPH_COUNT);
	localparam int unsigned ROW_W       = $clog2(GLYPH_SIZE);
	localparam int unsigned BIT_W       = $clog2(GLYPH_SIZE);

	localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(GLYPH_SIZE - 1);
	localparam logic [15:0]      CURSOR_ADV = 16'(GLYPH_SIZE + 1);

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_Z    = 8'h5A;
	localparam logic [7:0] LETTER_BASE = 8'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN
	} seq_state_t;

	typedef struct packed {
		logic               en;
		logic [GLYPH_W-1:0] glyph;
		logic [ROW_W-1:0]   row;
	} rom_rd_t;

	typedef struct packed {
		logic               valid;
		logic [GLYPH_W-1:0] glyph;
		logic [15:0]        x;
		logic [15:0]        y;
		logic [7:0]         color;
	} start_cmd_t;

endpackage

>>> hdl/bitmap_font_text_renderer_core.sv
// bitmap_font_text_renderer_core: top level, character beat intake and cursor
// depends on bftr_pkg, bftr_glyph_rom, bftr_seq
//
// Draws one character per input beat from a fixed 8x8 font of digits and capitals,
// emitting one pixel beat per set glyph bit, rows top to bottom and within a row
// from bit 0 upward, column cursor+8-k; the final beat of a glyph carries last.
// Other codes draw nothing. The cursor loads from start_x on new_string and moves
// right by 9 after every character. A drawing character keeps the block busy until
// its rows are scanned, longer under output stall: the font ROM read of row 0 comes
// first, later rows are prefetched while the current row is scanned one bit per
// cycle unless pixel_stall holds it. A non-drawing character never sets busy.
module bitmap_font_text_renderer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  ch,
	input  logic [15:0] start_x,
	input  logic [15:0] start_y,
	input  logic [7:0]  color,
	input  logic        new_string,
	output logic        pixel_valid,
	input  logic        pixel_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [7:0]  pixel_color,
	output logic        last
);

	logic                                  busy;
	logic                                  accept;
	logic [15:0]                           cursor_q;
	logic [15:0]                           base_x;
	logic                                  is_digit;
	logic                                  is_letter;
	logic [7:0]                            glyph_full;
	bftr_pkg::start_cmd_t                  cmd;
	bftr_pkg::rom_rd_t                     rom_rd;
	logic [bftr_pkg::GLYPH_SIZE-1:0]       rom_rdata;

	assign char_stall = busy;
	assign accept     = char_valid && !char_stall;
	assign base_x     = new_string ? start_x : cursor_q;

	assign is_digit  = (ch >= bftr_pkg::CH_ZERO) && (ch <= bftr_pkg::CH_NINE);
	assign is_letter = (ch >= bftr_pkg::CH_A) && (ch <= bftr_pkg::CH_Z);
	assign glyph_full = is_digit ? (ch - bftr_pkg::CH_ZERO)
		: (ch - bftr_pkg::CH_A + bftr_pkg::LETTER_BASE);

	always_comb begin
		cmd.valid = accept && (is_digit || is_letter);
		cmd.glyph = glyph_full[bftr_pkg::GLYPH_W-1:0];
		cmd.x     = base_x;
		cmd.y     = start_y;
		cmd.color = color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			cursor_q <= base_x + bftr_pkg::CURSOR_ADV;
		end
	end

	bftr_glyph_rom u_rom (
		.clk   (clk),
		.rd    (rom_rd),
		.rdata (rom_rdata)
	);

	bftr_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.busy        (busy),
		.rom_rd      (rom_rd),
		.rom_rdata   (rom_rdata),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule

>>> hdl/bftr_glyph_rom.sv
// bftr_glyph_rom: 36 x 8 row glyph font, synchronous read with a registered output
// depends on bftr_pkg
module bftr_glyph_rom (
	input  logic                      clk,
	input  bftr_pkg::rom_rd_t         rd,
	output logic [bftr_pkg::GLYPH_SIZE-1:0] rdata
);

	localparam logic [7:0] FONT [bftr_pkg::GLYPH_COUNT][bftr_pkg::GLYPH_SIZE] = '{
		'{8'h7E, 8'hC3, 8'hC7, 8'hCF, 8'hDB, 8'hF3, 8'hE3, 8'h7E},
		'{8'h18, 8'h38, 8'h38, 8'h18, 8'h18, 8'h18, 8'h7E, 8'h7E},
		'{8'h3C, 8'hE7, 8'h07, 8'h06, 8'h1E, 8'h78, 8'hE3, 8'hFF},
		'{8'h3C, 8'hE7, 8'h07, 8'h1C, 8'h07, 8'h07, 8'hE6, 8'h3C},
		'{8'h1C, 8'h3C, 8'h6C, 8'hCC, 8'hCC, 8'hFE, 8'h0C, 8'h1E},
		'{8'hFF, 8'hC0, 8'hFE, 8'h07, 8'h07, 8'h07, 8'hC6, 8'h7E},
		'{8'h1C, 8'h30, 8'h60, 8'hC0, 8'hFE, 8'hC3, 8'hC3, 8'h7E},
		'{8'hFF, 8'hFF, 8'hC7, 8'h07, 8'h0E, 8'h38, 8'h38, 8'h38},
		'{8'h7E, 8'h7E, 8'hC3, 8'hC3, 8'h7E, 8'hC3, 8'hC3, 8'h7E},
		'{8'h7E, 8'hC3, 8'hC3, 8'h7F, 8'h03, 8'h07, 8'h0E, 8'h7C},
		'{8'h18, 8'h3C, 8'h66, 8'hC3, 8'hC3, 8'hFF, 8'hC3, 8'hC3},
		'{8'hFC, 8'h66, 8'h66, 8'h7C, 8'h7C, 8'h66, 8'h66, 8'hFC},
		'{8'h3E, 8'h63, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'h63, 8'h3E},
		'{8'hFC, 8'h66, 8'h63, 8'h63, 8'h63, 8'h63, 8'h66, 8'hFC},
		'{8'hFF, 8'h61, 8'h60, 8'h64, 8'h7C, 8'h64, 8'h61, 8'hFF},
		'{8'hFF, 8'h61, 8'h60, 8'h64, 8'h7C, 8'h64, 8'h60, 8'hF0},
		'{8'h3E, 8'h63, 8'hC0, 8'hC0, 8'hC7, 8'hE3, 8'h63, 8'h3F},
		'{8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hFF, 8'hC3, 8'hC3, 8'hC3},
		'{8'h7E, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
		'{8'h0F, 8'h06, 8'h06, 8'h06, 8'h06, 8'hC6, 8'hC6, 8'h7C},
		'{8'hE3, 8'h63, 8'h66, 8'h6C, 8'h78, 8'h6C, 8'h66, 8'hE3},
		'{8'hF0, 8'h60, 8'h60, 8'h60, 8'h60, 8'h61, 8'h63, 8'hFF},
		'{8'hC3, 8'hE7, 8'hFF, 8'hFF, 8'hDB, 8'hC3, 8'hC3, 8'hC3},
		'{8'hC3, 8'hE3, 8'hF3, 8'hDB, 8'hCF, 8'hC7, 8'hC3, 8'hC3},
		'{8'h3C, 8'h66, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h66, 8'h3C},
		'{8'hFE, 8'h63, 8'h63, 8'h63, 8'h7E, 8'h60, 8'h60, 8'hF0},
		'{8'h7E, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hCF, 8'h7E, 8'h0F},
		'{8'hFE, 8'h63, 8'h63, 8'h7E, 8'h6E, 8'h66, 8'h63, 8'hE3},
		'{8'h7E, 8'hC3, 8'hE0, 8'h70, 8'h1F, 8'h03, 8'hC6, 8'h7C},
		'{8'hFF, 8'h99, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C},
		'{8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hE7, 8'h7E},
		'{8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h3C, 8'h18},
		'{8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hDB, 8'hFF, 8'hE7, 8'hC3},
		'{8'hC3, 8'hC3, 8'h66, 8'h66, 8'h3C, 8'h3C, 8'h67, 8'hC3},
		'{8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h7E, 8'h18, 8'h18, 8'h3C},
		'{8'hFF, 8'hC3, 8'h86, 8'h0C, 8'h18, 8'h31, 8'h63, 8'hFF}
	};

	logic [bftr_pkg::GLYPH_SIZE-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= FONT[rd.glyph][rd.row];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/bftr_seq.sv
// bftr_seq: row fetch and bit scan sequencer with the pixel output register
// depends on bftr_pkg, drives the read port of bftr_glyph_rom
module bftr_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bftr_pkg::start_cmd_t            cmd,
	output logic                            busy,
	output bftr_pkg::rom_rd_t               rom_rd,
	input  logic [bftr_pkg::GLYPH_SIZE-1:0] rom_rdata,
	output logic                            pixel_valid,
	input  logic                            pixel_stall,
	output logic [15:0]                     pixel_x,
	output logic [15:0]                     pixel_y,
	output logic [7:0]                      pixel_color,
	output logic                            last
);

	localparam int unsigned GS = bftr_pkg::GLYPH_SIZE;

	bftr_pkg::seq_state_t state_q, state_d;

	logic [bftr_pkg::GLYPH_W-1:0] glyph_q;
	logic [bftr_pkg::ROW_W-1:0]   row_q;
	logic [GS-1:0]                mask_q;
	logic [15:0]                  x_q;
	logic [15:0]                  y_q;
	logic [7:0]                   color_q;

	logic                         out_valid_q;
	logic [15:0]                  out_x_q;
	logic [15:0]                  out_y_q;
	logic [7:0]                   out_color_q;
	logic                         out_last_q;

	logic [bftr_pkg::BIT_W-1:0]   bit_k;
	logic [GS-1:0]                mask_next;
	logic                         out_free;
	logic                         step;
	logic                         emit;
	logic                         row_done;
	logic                         final_row;

	// lowest set bit of the current row
	always_comb begin
		bit_k = '0;
		for (int i = GS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				bit_k = bftr_pkg::BIT_W'(i);
			end
		end
	end

	assign mask_next = mask_q & (mask_q - GS'(1));
	assign out_free  = !out_valid_q || !pixel_stall;
	assign final_row = (row_q == bftr_pkg::LAST_ROW);
	assign step      = (state_q == bftr_pkg::ST_SCAN) && (out_free || (mask_q == '0));
	assign emit      = (state_q == bftr_pkg::ST_SCAN) && out_free && (mask_q != '0);
	assign row_done  = step && (mask_next == '0);
	assign busy      = (state_q != bftr_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bftr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rom_rd  = '0;
		unique case (state_q)
			bftr_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_d      = bftr_pkg::ST_FETCH;
					rom_rd.en    = 1'b1;
					rom_rd.glyph = cmd.glyph;
					rom_rd.row   = '0;
				end
			end
			bftr_pkg::ST_FETCH: begin
				// row 0 arrives now, prefetch row 1
				state_d      = bftr_pkg::ST_SCAN;
				rom_rd.en    = 1'b1;
				rom_rd.glyph = glyph_q;
				rom_rd.row   = bftr_pkg::ROW_W'(1);
			end
			bftr_pkg::ST_SCAN: begin
				if (row_done) begin
					if (final_row) begin
						state_d = bftr_pkg::ST_IDLE;
					end else if (row_q < bftr_pkg::LAST_ROW - bftr_pkg::ROW_W'(1)) begin
						rom_rd.en    = 1'b1;
						rom_rd.glyph = glyph_q;
						rom_rd.row   = row_q + bftr_pkg::ROW_W'(2);
					end
				end
			end
			default: begin
				state_d = bftr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			row_q  <= '0;
		end else begin
			if (state_q == bftr_pkg::ST_IDLE && cmd.valid) begin
				row_q <= '0;
			end else if (state_q == bftr_pkg::ST_FETCH) begin
				mask_q <= rom_rdata;
			end else if (step) begin
				if (row_done && !final_row) begin
					mask_q <= rom_rdata;
					row_q  <= row_q + bftr_pkg::ROW_W'(1);
				end else begin
					mask_q <= mask_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bftr_pkg::ST_IDLE && cmd.valid) begin
			glyph_q <= cmd.glyph;
			x_q     <= cmd.x;
			y_q     <= cmd.y;
			color_q <= cmd.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!pixel_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// bit k lands at column cursor + 8 - k
	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q     <= x_q + 16'(GS) - 16'(bit_k);
			out_y_q     <= y_q + 16'(row_q);
			out_color_q <= color_q;
			out_last_q  <= final_row && (mask_next == '0);
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_color = out_color_q;
	assign last        = out_last_q;

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> state_q == bftr_pkg::ST_IDLE)
		else $error("start command while sequencer busy");

	a_last_ends_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		emit && final_row && (mask_next == '0) |=> state_q == bftr_pkg::ST_IDLE)
		else $error("sequencer still busy after last beat");

	a_idle_mask_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bftr_pkg::ST_IDLE |-> mask_q == '0)
		else $error("pending glyph bits while idle");

	a_row_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bftr_pkg::ST_FETCH |=> mask_q != '0)
		else $error("glyph row 0 empty");

endmodule
